// ----- hdl/tasls_pkg.sv -----
// Package for the tilt-aware status LED sequencer.
// Holds action, mode and register codes, sequencer states and arithmetic constants.
// Depends on nothing; the top level imports it.
`default_nettype none

package tasls_pkg;

  // Action codes carried by an input beat
  localparam logic [1:0] ACT_TICK    = 2'd0;
  localparam logic [1:0] ACT_SET_NET = 2'd1;
  localparam logic [1:0] ACT_STOP    = 2'd2;

  // LED modes
  localparam logic [1:0] MODE_NOT_FORMED = 2'd0;
  localparam logic [1:0] MODE_FORMED     = 2'd1;
  localparam logic [1:0] MODE_TILTED     = 2'd2;

  // Configuration register indexes
  localparam int unsigned REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_WHITE_RED   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_WHITE_GREEN = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_WHITE_BLUE  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TILT_ON     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TILT_OFF    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MIN_MAG     = 3'd5;
  localparam int unsigned CFG_DATA_W = 32;

  // Register reset values
  localparam logic [7:0]  WHITE_RESET   = 8'd255;
  localparam logic [15:0] TILT_ON_RESET = 16'd4979;
  localparam logic [15:0] TILT_OFF_RESET = 16'd2833;
  localparam logic [31:0] MIN_MAG_RESET = 32'd10000;

  // Timing constants, in ticks
  localparam int unsigned CHECK_PERIOD = 25;
  localparam int unsigned PULSE_PERIOD = 690;
  localparam int unsigned PULSE_HALF   = 345;
  localparam int unsigned BLINK_HALF   = 62;
  localparam int unsigned BLINK_PERIOD = 2 * BLINK_HALF;
  localparam int unsigned CHECK_W = $clog2(CHECK_PERIOD);
  localparam int unsigned STEP_W  = $clog2(PULSE_PERIOD);
  localparam int unsigned BLINK_W = $clog2(BLINK_PERIOD);

  // Brightness constants
  localparam int unsigned PULSE_MIN  = 25;
  localparam int unsigned FULL_LEVEL = 255;

  // Reciprocal multipliers: floor(n/3) for n < 2045, floor(p/255) for 16-bit p
  localparam logic [15:0] DIV3_RECIP   = 16'd683;
  localparam int unsigned DIV3_SHIFT   = 11;
  localparam logic [15:0] DIV255_RECIP = 16'd32897;
  localparam int unsigned DIV255_SHIFT = 23;

  // Colour channel select
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_Z,
    ST_SUM,
    ST_SCALE,
    ST_TILT,
    ST_ANIM,
    ST_BRIGHT,
    ST_CH_MUL,
    ST_CH_DIV,
    ST_CH_STORE,
    ST_WRITE
  } state_t;

endpackage

`default_nettype wire

// ----- hdl/tasls_if.sv -----
// Channel interfaces of the tilt-aware status LED sequencer.
// Event channel in, LED result channel out; valid/ready handshake.
// No dependencies.
`default_nettype none

interface tasls_evt_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic               net_formed;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;

  modport source (output valid, action, net_formed, accel_x, accel_y, accel_z,
                  input ready);
  modport sink   (input valid, action, net_formed, accel_x, accel_y, accel_z,
                  output ready);
endinterface

interface tasls_led_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [1:0] led_mode;
  logic       led_written;

  modport source (output valid, red, green, blue, led_mode, led_written, input ready);
  modport sink   (input valid, red, green, blue, led_mode, led_written, output ready);
endinterface

`default_nettype wire

// ----- hdl/tilt_aware_status_led_sequencer.sv -----
// Top level of the tilt-aware status LED sequencer.
// Uses tasls_pkg for codes and constants, tasls_if.sv for the channel interfaces.
// Holds the sequencer, the shared 16x32 multiplier and all state.
//
// Channel  Dir  Beat carries                                        Handshake
// evt      in   action, net_formed, accel_x/y/z                     valid/ready
// led      out  red, green, blue, led_mode, led_written             valid/ready
// wr       in   wr_index, wr_data                                   wr_en, no wait
//
// Path per event beat: IDLE, WRITE for a non-tick event or a stopped tick;
// IDLE, ANIM, WRITE for a blink or formed tick; BRIGHT and CH_MUL, CH_DIV,
// CH_STORE per channel for a pulse tick; SQ_X to TILT first on every 25th
// tick. All products pass in turn through the single registered 16x32 multiplier.
// Reset (rst, synchronous) restores register defaults and clears the control and architectural state.
// evt.ready is high only while the sequencer is idle; a result waiting on
// led does not block the next event beat until that beat's own result.
`default_nettype none

module tilt_aware_status_led_sequencer (
  input  wire logic                                clk,
  input  wire logic                                rst,
  tasls_evt_if.sink                                evt,
  tasls_led_if.source                              led,
  input  wire logic                                wr_en,
  input  wire logic [tasls_pkg::REG_IDX_W-1:0]     wr_index,
  input  wire logic [tasls_pkg::CFG_DATA_W-1:0]    wr_data
);

  import tasls_pkg::*;

  // Configuration
  logic [7:0]  white_red, white_green, white_blue;
  logic [15:0] tilt_on_sin_sq, tilt_off_sin_sq;
  logic [31:0] min_magnitude_sq;

  // Architectural state
  logic [31:0]        tick_count;
  logic [CHECK_W-1:0] check_cnt;   // tick_count mod 25
  logic [STEP_W-1:0]  pulse_step;  // tick_count mod 690
  logic [BLINK_W-1:0] blink_cnt;   // tick_count mod 124
  logic [1:0]         mode;
  logic               previously_tilted;
  logic               network_is_formed;
  logic               timer_running;
  logic [7:0]         color_r, color_g, color_b;

  // Working registers
  state_t      state, state_next;
  logic [15:0] mag_x, mag_y, mag_z;
  logic [31:0] horiz_sq, total_sq;
  logic [47:0] prod;
  logic [7:0]  bright;
  logic [1:0]  ch;
  logic        written;

  // Output register
  logic        out_valid;
  logic [7:0]  out_red, out_green, out_blue;
  logic [1:0]  out_mode;
  logic        out_written;

  // Combinational helpers
  logic               accept;
  logic               wrap;
  logic [CHECK_W-1:0] check_cnt_next;
  logic [STEP_W-1:0]  pulse_step_next;
  logic [BLINK_W-1:0] blink_cnt_next;
  logic               check_due;
  logic               rising;
  logic [STEP_W-1:0]  pulse_n;
  logic [7:0]         white_sel;
  logic [15:0]        sin_sel;
  logic               tilted;
  logic [15:0]        mul_a;
  logic [31:0]        mul_b;
  logic               out_free;

  assign accept   = evt.valid && evt.ready;
  assign out_free = !out_valid || led.ready;

  // Residue counters follow tick_count; a wrap of tick_count to zero zeroes them
  assign wrap = &tick_count;
  assign check_cnt_next = (wrap || check_cnt == CHECK_W'(CHECK_PERIOD - 1)) ?
                          '0 : check_cnt + 1'b1;
  assign pulse_step_next = (wrap || pulse_step == STEP_W'(PULSE_PERIOD - 1)) ?
                           '0 : pulse_step + 1'b1;
  assign blink_cnt_next = (wrap || blink_cnt == BLINK_W'(BLINK_PERIOD - 1)) ?
                          '0 : blink_cnt + 1'b1;
  assign check_due = (check_cnt_next == '0);

  // Triangle: brightness offset is floor(2*k/3), k the distance into the half
  assign rising  = (pulse_step < STEP_W'(PULSE_HALF));
  assign pulse_n = rising ? {pulse_step[STEP_W-2:0], 1'b0}
                          : STEP_W'({pulse_step - STEP_W'(PULSE_HALF), 1'b0});

  assign sin_sel = previously_tilted ? tilt_off_sin_sq : tilt_on_sin_sq;

  // Tilted when h * 2^16 > s * t, with t at or above the floor
  assign tilted = (total_sq >= min_magnitude_sq) && ({horiz_sq, 16'h0000} > prod);

  always_comb begin
    case (ch)
      CH_RED:   white_sel = white_red;
      CH_GREEN: white_sel = white_green;
      default:  white_sel = white_blue;
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (evt.action == ACT_TICK && timer_running) begin
            state_next = check_due ? ST_SQ_X : ST_ANIM;
          end else begin
            state_next = ST_WRITE;
          end
        end
      end
      ST_SQ_X:  state_next = ST_SQ_Y;
      ST_SQ_Y:  state_next = ST_SQ_Z;
      ST_SQ_Z:  state_next = ST_SUM;
      ST_SUM:   state_next = ST_SCALE;
      ST_SCALE: state_next = ST_TILT;
      ST_TILT:  state_next = ST_ANIM;
      ST_ANIM:  state_next = (mode == MODE_NOT_FORMED) ? ST_BRIGHT : ST_WRITE;
      ST_BRIGHT:   state_next = ST_CH_MUL;
      ST_CH_MUL:   state_next = ST_CH_DIV;
      ST_CH_DIV:   state_next = ST_CH_STORE;
      ST_CH_STORE: state_next = (ch == CH_BLUE) ? ST_WRITE : ST_CH_MUL;
      ST_WRITE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake and multiplier operands
  always_comb begin
    evt.ready = (state == ST_IDLE);
    mul_a     = '0;
    mul_b     = '0;
    case (state)
      ST_SQ_X: begin
        mul_a = mag_x;
        mul_b = 32'(mag_x);
      end
      ST_SQ_Y: begin
        mul_a = mag_y;
        mul_b = 32'(mag_y);
      end
      ST_SQ_Z: begin
        mul_a = mag_z;
        mul_b = 32'(mag_z);
      end
      ST_SCALE: begin
        mul_a = sin_sel;
        mul_b = total_sq;
      end
      ST_ANIM: begin
        mul_a = DIV3_RECIP;
        mul_b = 32'(pulse_n);
      end
      ST_CH_MUL: begin
        mul_a = 16'(white_sel);
        mul_b = 32'(bright);
      end
      ST_CH_DIV: begin
        mul_a = DIV255_RECIP;
        mul_b = 32'(prod[15:0]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Shared multiplier, registered
  always_ff @(posedge clk) begin
    prod <= 48'(mul_a) * 48'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      white_red        <= WHITE_RESET;
      white_green      <= WHITE_RESET;
      white_blue       <= WHITE_RESET;
      tilt_on_sin_sq   <= TILT_ON_RESET;
      tilt_off_sin_sq  <= TILT_OFF_RESET;
      min_magnitude_sq <= MIN_MAG_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_WHITE_RED:   white_red        <= wr_data[7:0];
        REG_WHITE_GREEN: white_green      <= wr_data[7:0];
        REG_WHITE_BLUE:  white_blue       <= wr_data[7:0];
        REG_TILT_ON:     tilt_on_sin_sq   <= wr_data[15:0];
        REG_TILT_OFF:    tilt_off_sin_sq  <= wr_data[15:0];
        REG_MIN_MAG:     min_magnitude_sq <= wr_data[31:0];
        default: ;
      endcase
    end
  end

  // Control state and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count        <= '0;
      check_cnt         <= '0;
      pulse_step        <= '0;
      blink_cnt         <= '0;
      mode              <= MODE_NOT_FORMED;
      previously_tilted <= 1'b0;
      network_is_formed <= 1'b0;
      timer_running     <= 1'b0;
      color_r           <= '0;
      color_g           <= '0;
      color_b           <= '0;
      ch                <= CH_RED;
      written           <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            // Latch magnitudes; -32768 maps onto 32768 in 16 unsigned bits
            mag_x   <= evt.accel_x[15] ? 16'(-evt.accel_x) : evt.accel_x;
            mag_y   <= evt.accel_y[15] ? 16'(-evt.accel_y) : evt.accel_y;
            mag_z   <= evt.accel_z[15] ? 16'(-evt.accel_z) : evt.accel_z;
            case (evt.action)
              ACT_TICK: begin
                // A tick while stopped leaves the counters and colours as they are
                written <= timer_running;
                if (timer_running) begin
                  tick_count <= tick_count + 1'b1;
                  check_cnt  <= check_cnt_next;
                  pulse_step <= pulse_step_next;
                  blink_cnt  <= blink_cnt_next;
                end
              end
              ACT_SET_NET: begin
                network_is_formed <= evt.net_formed;
                written           <= evt.net_formed;
                if (evt.net_formed) begin
                  timer_running <= 1'b0;
                  color_r       <= '0;
                  color_g       <= '0;
                  color_b       <= '0;
                  mode          <= MODE_FORMED;
                end else begin
                  timer_running <= 1'b1;
                  if (mode != MODE_TILTED) begin
                    mode <= MODE_NOT_FORMED;
                  end
                end
              end
              ACT_STOP: begin
                timer_running <= 1'b0;
                color_r       <= '0;
                color_g       <= '0;
                color_b       <= '0;
                written       <= 1'b1;
              end
              default: written <= 1'b0;
            endcase
          end
        end
        ST_SQ_Y: horiz_sq <= prod[31:0];
        ST_SQ_Z: horiz_sq <= horiz_sq + prod[31:0];
        ST_SUM:  total_sq <= horiz_sq + prod[31:0];
        ST_TILT: begin
          // Hysteresis: enter or leave tilted, fall back to the network mode
          if (tilted && mode != MODE_TILTED) begin
            mode <= MODE_TILTED;
          end else if (!tilted && mode == MODE_TILTED) begin
            mode <= network_is_formed ? MODE_FORMED : MODE_NOT_FORMED;
          end
          previously_tilted <= tilted;
        end
        ST_ANIM: begin
          if (mode == MODE_FORMED) begin
            color_r <= '0;
            color_g <= '0;
            color_b <= '0;
          end else if (mode == MODE_TILTED) begin
            // Second half of each 124-tick period lights white
            if (blink_cnt >= BLINK_W'(BLINK_HALF)) begin
              color_r <= white_red;
              color_g <= white_green;
              color_b <= white_blue;
            end else begin
              color_r <= '0;
              color_g <= '0;
              color_b <= '0;
            end
          end
        end
        ST_BRIGHT: begin
          bright <= rising ? 8'(PULSE_MIN) + prod[DIV3_SHIFT +: 8]
                           : 8'(FULL_LEVEL) - prod[DIV3_SHIFT +: 8];
          ch     <= CH_RED;
        end
        ST_CH_STORE: begin
          case (ch)
            CH_RED:   color_r <= prod[DIV255_SHIFT +: 8];
            CH_GREEN: color_g <= prod[DIV255_SHIFT +: 8];
            default:  color_b <= prod[DIV255_SHIFT +: 8];
          endcase
          ch <= ch + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Output register: load on the final step, drop once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_WRITE && out_free) begin
      out_valid <= 1'b1;
    end else if (led.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_WRITE && out_free) begin
      out_red     <= color_r;
      out_green   <= color_g;
      out_blue    <= color_b;
      out_mode    <= mode;
      out_written <= written;
    end
  end

  assign led.valid       = out_valid;
  assign led.red         = out_red;
  assign led.green       = out_green;
  assign led.blue        = out_blue;
  assign led.led_mode    = out_mode;
  assign led.led_written = out_written;

  // Residue counters stay within their periods
  a_residue_range: assert property (@(posedge clk) disable iff (rst)
    check_cnt < CHECK_W'(CHECK_PERIOD) && pulse_step < STEP_W'(PULSE_PERIOD) &&
    blink_cnt < BLINK_W'(BLINK_PERIOD))
    else $error("residue counter out of range");

  // A zero tick count implies zero residues
  a_residue_zero: assert property (@(posedge clk) disable iff (rst)
    tick_count == '0 |-> check_cnt == '0 && pulse_step == '0 && blink_cnt == '0)
    else $error("residues out of step with tick count");

  // The tilt test runs only on every 25th tick
  a_check_tick: assert property (@(posedge clk) disable iff (rst)
    state == ST_SQ_X |-> check_cnt == '0)
    else $error("tilt test off its period");

  // Formed network halts ticking and blanks the LEDs
  a_formed: assert property (@(posedge clk) disable iff (rst)
    accept && evt.action == ACT_SET_NET && evt.net_formed |=>
    !timer_running && mode == MODE_FORMED && color_r == '0 && color_g == '0 &&
    color_b == '0)
    else $error("formed event not applied");

  // Stop halts ticking and blanks the LEDs
  a_stop: assert property (@(posedge clk) disable iff (rst)
    accept && evt.action == ACT_STOP |=>
    !timer_running && color_r == '0 && color_g == '0 && color_b == '0)
    else $error("stop event not applied");

endmodule

`default_nettype wire
